### rtl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants for the packet deframer
// Parse phases, register indexes, reset values and the structs that travel
// between the register file, the parser and the emitter.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 6;
  localparam int unsigned IdxOutW = 5;
  localparam int unsigned HeaderBytes = 3;

  typedef enum logic [1:0] {
    PhHunt    = 2'd0,
    PhHeader  = 2'd1,
    PhPayload = 2'd2,
    PhCheck   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RegSync    = 2'd0,
    RegSize    = 2'd1,
    RegDevice  = 2'd2,
    RegMessage = 2'd3
  } reg_idx_e;

  localparam logic [ByteW-1:0] SyncReset    = 8'hFF;
  localparam logic [ByteW-1:0] SizeReset    = 8'h26;
  localparam logic [ByteW-1:0] DeviceReset  = 8'hFF;
  localparam logic [ByteW-1:0] MessageReset = 8'h14;

  typedef struct packed {
    logic [ByteW-1:0] sync_value;
    logic [ByteW-1:0] size_value;
    logic [ByteW-1:0] device_value;
    logic [ByteW-1:0] message_value;
  } cfg_t;

  // Payload store write request; the slot index travels beside it.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [ByteW-1:0] data;
  } wr_t;

  // Release of a payload bank once its last word has been read.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

### rtl/imu_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// imu_packet_deframer_top: sync/header/checksum packet deframer
// Parser, token queue and payload emitter with a double-banked store.
// ----------------------------------------------------------------------------
// The parser takes one received word per cycle. Payload bytes go into one of
// two banks of the payload store; when the checksum matches, the bank number
// is queued and the emitter reads that bank out, one word per cycle while the
// output side takes them, with the last one marked. The only input stall
// comes from the store: a payload word waits while the bank it would fill
// still holds a packet that has not been read out. With a 38-word packet
// and a 30-word payload, reception continues at full rate as long as the
// output side takes words at least as fast as they arrive.
// ----------------------------------------------------------------------------
module imu_packet_deframer_top #(
  parameter int unsigned PACKET_LENGTH = 38,
  parameter int unsigned SYNC_COUNT    = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [ipd_pkg::ByteW-1:0]     cfg_wdata_i,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [ipd_pkg::ByteW-1:0]     rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ipd_pkg::ByteW-1:0]     payload_byte_o,
  output logic [ipd_pkg::IdxOutW-1:0]   payload_index_o,
  output logic                          last_byte_o
);

  localparam int unsigned PayloadLen =
    PACKET_LENGTH - SYNC_COUNT - ipd_pkg::HeaderBytes - 1;
  localparam int unsigned IdxW = (PayloadLen > 1) ? $clog2(PayloadLen) : 1;

  ipd_pkg::cfg_t   cfg_q;
  ipd_pkg::wr_t    wr;
  ipd_pkg::rel_t   rel;
  logic [IdxW-1:0] wr_idx;
  logic            push, push_bank;
  logic            pop, pop_bank, tok_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value    <= ipd_pkg::SyncReset;
      cfg_q.size_value    <= ipd_pkg::SizeReset;
      cfg_q.device_value  <= ipd_pkg::DeviceReset;
      cfg_q.message_value <= ipd_pkg::MessageReset;
    end else if (cfg_we_i) begin
      unique case (ipd_pkg::reg_idx_e'(cfg_idx_i))
        ipd_pkg::RegSync:    cfg_q.sync_value    <= cfg_wdata_i;
        ipd_pkg::RegSize:    cfg_q.size_value    <= cfg_wdata_i;
        ipd_pkg::RegDevice:  cfg_q.device_value  <= cfg_wdata_i;
        ipd_pkg::RegMessage: cfg_q.message_value <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ipd_front #(
    .PACKET_LENGTH (PACKET_LENGTH),
    .SYNC_COUNT    (SYNC_COUNT),
    .IdxW          (IdxW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .wr_o        (wr),
    .wr_idx_o    (wr_idx),
    .push_o      (push),
    .push_bank_o (push_bank),
    .rel_i       (rel)
  );

  ipd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bank),
    .pop_i       (pop),
    .pop_data_o  (pop_bank),
    .empty_o     (tok_empty)
  );

  ipd_back #(
    .PayloadLen (PayloadLen),
    .IdxW       (IdxW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .wr_idx_i        (wr_idx),
    .tok_empty_i     (tok_empty),
    .tok_bank_i      (pop_bank),
    .tok_pop_o       (pop),
    .rel_o           (rel),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .last_byte_o     (last_byte_o)
  );

endmodule

### rtl/ipd_front.sv
// ----------------------------------------------------------------------------
// ipd_front: byte parser
// Hunts for sync, checks the header, writes payload bytes into the free bank
// and queues the bank number when the checksum matches.
// ----------------------------------------------------------------------------
module ipd_front #(
  parameter int unsigned PACKET_LENGTH = 38,
  parameter int unsigned SYNC_COUNT    = 4,
  parameter int unsigned IdxW          = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ipd_pkg::cfg_t              cfg_i,
  input  logic                       rx_valid_i,
  output logic                       rx_ready_o,
  input  logic [ipd_pkg::ByteW-1:0]  rx_byte_i,
  output ipd_pkg::wr_t               wr_o,
  output logic [IdxW-1:0]            wr_idx_o,
  output logic                       push_o,
  output logic                       push_bank_o,
  input  ipd_pkg::rel_t              rel_i
);

  localparam int unsigned HeaderEnd  = SYNC_COUNT + ipd_pkg::HeaderBytes;
  localparam int unsigned CheckPos   = PACKET_LENGTH - 1;
  localparam int unsigned PayloadLen = PACKET_LENGTH - SYNC_COUNT - ipd_pkg::HeaderBytes - 1;

  ipd_pkg::phase_e                phase_q, phase_d;
  logic [ipd_pkg::PosW-1:0]       pos_q, pos_d;
  logic [ipd_pkg::ByteW-1:0]      sum_q, sum_d;
  logic                           bank_q, bank_d;
  logic [1:0]                     busy_q, busy_d;

  logic                           accept;
  logic [ipd_pkg::PosW-1:0]       pos_inc;
  logic [ipd_pkg::PosW-1:0]       hdr_k;
  logic [ipd_pkg::PosW-1:0]       slot;
  logic [ipd_pkg::ByteW-1:0]      want;

  // Payload bytes wait while the bank they would land in is still queued or being read out.
  assign rx_ready_o = (phase_q != ipd_pkg::PhPayload) || !busy_q[bank_q];
  assign accept     = rx_valid_i && rx_ready_o;
  assign pos_inc    = pos_q + 1'b1;
  assign hdr_k      = pos_q - ipd_pkg::PosW'(SYNC_COUNT);
  assign slot       = pos_q - ipd_pkg::PosW'(HeaderEnd);

  always_comb begin
    unique case (hdr_k[1:0])
      2'd0:    want = cfg_i.size_value;
      2'd1:    want = cfg_i.device_value;
      default: want = cfg_i.message_value;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    bank_d      = bank_q;
    busy_d      = busy_q;
    wr_o.en     = 1'b0;
    wr_o.bank   = bank_q;
    wr_o.data   = rx_byte_i;
    wr_idx_o    = IdxW'(slot);
    push_o      = 1'b0;
    push_bank_o = bank_q;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      unique case (phase_q)
        ipd_pkg::PhHunt: begin
          if (rx_byte_i == cfg_i.sync_value) begin
            pos_d = pos_inc;
            sum_d = sum_q + rx_byte_i;
            if (pos_inc >= ipd_pkg::PosW'(SYNC_COUNT)) begin
              phase_d = ipd_pkg::PhHeader;
            end
          end else begin
            pos_d = '0;
            sum_d = '0;
          end
        end
        ipd_pkg::PhHeader: begin
          if (rx_byte_i == want) begin
            pos_d = pos_inc;
            sum_d = sum_q + rx_byte_i;
            if (pos_inc >= ipd_pkg::PosW'(HeaderEnd)) begin
              phase_d = (pos_inc >= ipd_pkg::PosW'(CheckPos)) ? ipd_pkg::PhCheck
                                                               : ipd_pkg::PhPayload;
            end
          end else begin
            phase_d = ipd_pkg::PhHunt;
            pos_d   = '0;
            sum_d   = '0;
          end
        end
        ipd_pkg::PhPayload: begin
          wr_o.en = 1'b1;
          pos_d   = pos_inc;
          sum_d   = sum_q + rx_byte_i;
          if (pos_inc >= ipd_pkg::PosW'(CheckPos)) begin
            phase_d = ipd_pkg::PhCheck;
          end
        end
        default: begin
          // A good checksum hands the filled bank to the emitter.
          if (rx_byte_i == sum_q && PayloadLen > 0) begin
            push_o         = 1'b1;
            busy_d[bank_q] = 1'b1;
            bank_d         = !bank_q;
          end
          phase_d = ipd_pkg::PhHunt;
          pos_d   = '0;
          sum_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ipd_pkg::PhHunt;
      pos_q   <= '0;
      sum_q   <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

### rtl/ipd_fifo.sv
// ----------------------------------------------------------------------------
// ipd_fifo: two-entry token queue
// Holds the bank numbers of good packets between parser and emitter.
// ----------------------------------------------------------------------------
module ipd_fifo (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic push_data_i,
  input  logic pop_i,
  output logic pop_data_o,
  output logic empty_o
);

  logic [1:0] mem_q;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // The parser never holds more than two banks, so a push always finds room.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/ipd_back.sv
// ----------------------------------------------------------------------------
// ipd_back: payload store and emitter
// Two payload banks in one memory; reads a queued bank out one word a cycle
// into the output register, as long as the output side takes them.
// ----------------------------------------------------------------------------
module ipd_back #(
  parameter int unsigned PayloadLen = 30,
  parameter int unsigned IdxW       = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ipd_pkg::wr_t                  wr_i,
  input  logic [IdxW-1:0]               wr_idx_i,
  input  logic                          tok_empty_i,
  input  logic                          tok_bank_i,
  output logic                          tok_pop_o,
  output ipd_pkg::rel_t                 rel_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ipd_pkg::ByteW-1:0]     payload_byte_o,
  output logic [ipd_pkg::IdxOutW-1:0]   payload_index_o,
  output logic                          last_byte_o
);

  localparam int unsigned Depth = 2 ** (IdxW + 1);

  logic [ipd_pkg::ByteW-1:0] mem [Depth];

  logic                      active_q;
  logic                      bank_q;
  logic [IdxW-1:0]           idx_q;
  logic                      out_valid_q;
  logic [ipd_pkg::ByteW-1:0] data_q;
  logic [IdxW-1:0]           out_idx_q;
  logic                      last_q;

  logic rd_en;
  logic is_last;

  assign tok_pop_o = !active_q && !tok_empty_i;
  assign rd_en     = active_q && (!out_valid_q || out_ready_i);
  assign is_last   = (idx_q == IdxW'(PayloadLen - 1));

  // Once the last word has left the store, the bank may be refilled.
  assign rel_o.valid = rd_en && is_last;
  assign rel_o.bank  = bank_q;

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = data_q;
  assign payload_index_o = ipd_pkg::IdxOutW'(out_idx_q);
  assign last_byte_o     = last_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[{wr_i.bank, wr_idx_i}] <= wr_i.data;
    end
    if (rd_en) begin
      data_q    <= mem[{bank_q, idx_q}];
      out_idx_q <= idx_q;
      last_q    <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      bank_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (tok_pop_o) begin
        active_q <= 1'b1;
        bank_q   <= tok_bank_i;
        idx_q    <= '0;
      end else if (rd_en) begin
        if (is_last) begin
          active_q <= 1'b0;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (rd_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### dv/imu_packet_deframer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_packet_deframer_checker: payload predictor and output comparator
// Tracks register writes and every received word the deframer accepts, works
// out the payload words a good packet releases, and compares each word taken
// from the output channel against the oldest one still owed.
// ----------------------------------------------------------------------------
module imu_packet_deframer_checker #(
  parameter int unsigned PACKET_LENGTH = 38,
  parameter int unsigned SYNC_COUNT    = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [ipd_pkg::ByteW-1:0]   cfg_wdata_i,
  input  logic                        rx_valid_i,
  input  logic                        rx_ready_i,
  input  logic [ipd_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [ipd_pkg::ByteW-1:0]   payload_byte_i,
  input  logic [ipd_pkg::IdxOutW-1:0] payload_index_i,
  input  logic                        last_byte_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  import ipd_pkg::*;

  localparam int unsigned HeaderEnd  = SYNC_COUNT + HeaderBytes;
  localparam int unsigned CheckPos   = PACKET_LENGTH - 1;
  localparam int unsigned PayloadLen = PACKET_LENGTH - SYNC_COUNT - HeaderBytes - 1;
  localparam int unsigned CopyDepth  = 64;

  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic [IdxOutW-1:0] index;
    logic               last;
  } payload_word_t;

  cfg_t               live_cfg;
  phase_e             parse_phase;
  logic [PosW-1:0]    byte_count;
  logic [ByteW-1:0]   byte_sum;
  logic [ByteW-1:0]   payload_copy [CopyDepth];
  payload_word_t      owed_words [$];
  int unsigned        mismatches = 0;
  int unsigned        owed_count = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = owed_count;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void restart_hunt();
    parse_phase = PhHunt;
    byte_count  = '0;
    byte_sum    = '0;
  endfunction

  function automatic void count_byte(input logic [ByteW-1:0] b);
    byte_sum   = byte_sum + b;
    byte_count = byte_count + 1'b1;
  endfunction

  // Advances the parser by one received word and queues the payload of a
  // packet whose checksum word matches the running sum.
  function automatic void track_rx_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] want;
    int unsigned      slot;
    payload_word_t    w;
    case (parse_phase)
      PhHunt: begin
        if (b == live_cfg.sync_value) begin
          count_byte(b);
          if (byte_count >= SYNC_COUNT) parse_phase = PhHeader;
        end else begin
          restart_hunt();
        end
      end
      PhHeader: begin
        case (int'(byte_count) - int'(SYNC_COUNT))
          0:       want = live_cfg.size_value;
          1:       want = live_cfg.device_value;
          default: want = live_cfg.message_value;
        endcase
        if (b == want) begin
          count_byte(b);
          if (byte_count >= HeaderEnd) begin
            parse_phase = (byte_count >= CheckPos) ? PhCheck : PhPayload;
          end
        end else begin
          // The offending word is dropped, even when it equals the sync value.
          restart_hunt();
        end
      end
      PhPayload: begin
        slot = int'(byte_count) - int'(HeaderEnd);
        if (slot < CopyDepth) payload_copy[slot] = b;
        count_byte(b);
        if (byte_count >= CheckPos) parse_phase = PhCheck;
      end
      default: begin
        if (b == byte_sum) begin
          for (int unsigned i = 0; i < PayloadLen && i < CopyDepth; i++) begin
            w.data  = payload_copy[i];
            w.index = IdxOutW'(i);
            w.last  = (i == PayloadLen - 1);
            owed_words.push_back(w);
          end
        end
        restart_hunt();
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    payload_word_t exp_w;
    if (!rst_ni) begin
      live_cfg.sync_value    = SyncReset;
      live_cfg.size_value    = SizeReset;
      live_cfg.device_value  = DeviceReset;
      live_cfg.message_value = MessageReset;
      restart_hunt();
      owed_words.delete();
    end else begin
      // A payload word never leaves the deframer at the edge that accepts its checksum word,
      // so the output side is checked before this edge's received word is counted.
      if (out_valid_i && out_ready_i) begin
        if (owed_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word byte=%02h index=%0d last=%b",
                                    payload_byte_i, payload_index_i, last_byte_i));
        end else begin
          exp_w = owed_words.pop_front();
          if (payload_byte_i !== exp_w.data)
            report_mismatch($sformatf("payload_byte got %02h, want %02h (index %0d)",
                                      payload_byte_i, exp_w.data, exp_w.index));
          if (payload_index_i !== exp_w.index)
            report_mismatch($sformatf("payload_index got %0d, want %0d",
                                      payload_index_i, exp_w.index));
          if (last_byte_i !== exp_w.last)
            report_mismatch($sformatf("last_byte got %b, want %b (index %0d)",
                                      last_byte_i, exp_w.last, exp_w.index));
        end
      end
      if (rx_valid_i && rx_ready_i) track_rx_byte(rx_byte_i);
      // A word received at the same edge as a write still sees the old value.
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegSync:    live_cfg.sync_value    = cfg_wdata_i;
          RegSize:    live_cfg.size_value    = cfg_wdata_i;
          RegDevice:  live_cfg.device_value  = cfg_wdata_i;
          RegMessage: live_cfg.message_value = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    owed_count = owed_words.size();
  end

endmodule

### dv/imu_packet_deframer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_packet_deframer_top_test: stimulus and verdict for the packet deframer
// Sends directed and random packet streams under several register settings
// and idle patterns; a checker beside the block predicts and compares every
// payload word.
// ----------------------------------------------------------------------------
module imu_packet_deframer_top_test;
  import ipd_pkg::*;

  localparam int unsigned PacketLength = 38;
  localparam int unsigned SyncCount    = 4;
  localparam int unsigned PayloadLen   = PacketLength - SyncCount - HeaderBytes - 1;
  localparam int unsigned HalfPeriod   = 6;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseBudget  = 12;
  localparam int unsigned TimeoutNs    = 2_000_000;

  typedef enum {PktGood, PktBadSum, PktBadHeader, PktShortSync, PktNoise} pkt_kind_e;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [1:0]           cfg_idx     = '0;
  logic [ByteW-1:0]     cfg_wdata   = '0;
  logic                 rx_valid    = 1'b0;
  logic                 rx_ready;
  logic [ByteW-1:0]     rx_byte     = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [ByteW-1:0]     payload_byte;
  logic [IdxOutW-1:0]   payload_index;
  logic                 last_byte;
  int unsigned          fail_count;
  int unsigned          pending;

  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  int unsigned          bytes_sent    = 0;
  cfg_t                 cur_cfg       = '{SyncReset, SizeReset, DeviceReset, MessageReset};

  imu_packet_deframer_top #(
    .PACKET_LENGTH (PacketLength),
    .SYNC_COUNT    (SyncCount)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .rx_valid_i      (rx_valid),
    .rx_ready_o      (rx_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .payload_byte_o  (payload_byte),
    .payload_index_o (payload_index),
    .last_byte_o     (last_byte)
  );

  imu_packet_deframer_checker #(
    .PACKET_LENGTH (PacketLength),
    .SYNC_COUNT    (SyncCount)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .rx_valid_i      (rx_valid),
    .rx_ready_i      (rx_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .payload_byte_i  (payload_byte),
    .payload_index_i (payload_index),
    .last_byte_i     (last_byte),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    clk = 1'b1;
    #(HalfPeriod);
    clk = 1'b0;
    #(HalfPeriod);
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet(input pkt_kind_e kind, input bit extreme_fill);
    logic [ByteW-1:0] hdr [HeaderBytes];
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    int               bad_k;
    int               k;
    sum = '0;
    if (kind == PktNoise) begin
      repeat ($urandom_range(5, 1)) send_byte(ByteW'($urandom_range(255)));
      return;
    end
    if (kind == PktShortSync) begin
      repeat ($urandom_range(SyncCount - 1, 1)) send_byte(cur_cfg.sync_value);
      send_byte(cur_cfg.sync_value ^ ByteW'($urandom_range(255, 1)));
      return;
    end
    hdr[0] = cur_cfg.size_value;
    hdr[1] = cur_cfg.device_value;
    hdr[2] = cur_cfg.message_value;
    bad_k  = (kind == PktBadHeader) ? int'($urandom_range(HeaderBytes - 1)) : -1;
    repeat (SyncCount) begin
      send_byte(cur_cfg.sync_value);
      sum += cur_cfg.sync_value;
    end
    for (k = 0; k < HeaderBytes; k++) begin
      if (k == bad_k) begin
        send_byte(hdr[k] ^ ByteW'($urandom_range(255, 1)));
        return;
      end
      send_byte(hdr[k]);
      sum += hdr[k];
    end
    for (k = 0; k < PayloadLen; k++) begin
      if (extreme_fill) b = k[0] ? 8'hFF : 8'h00;
      else if ($urandom_range(3) == 0) b = $urandom_range(1) ? 8'hFF : 8'h00;
      else b = ByteW'($urandom_range(255));
      send_byte(b);
      sum += b;
    end
    if (kind == PktBadSum) sum ^= ByteW'($urandom_range(255, 1));
    send_byte(sum);
  endtask

  // Only called while the block is idle.
  task automatic write_config(input cfg_t c);
    reg_idx_e         r;
    logic [ByteW-1:0] v;
    for (int i = 0; i < 4; i++) begin
      r = reg_idx_e'(i);
      case (r)
        RegSync:    v = c.sync_value;
        RegSize:    v = c.size_value;
        RegDevice:  v = c.device_value;
        default:    v = c.message_value;
      endcase
      cfg_we    <= 1'b1;
      cfg_idx   <= r;
      cfg_wdata <= v;
      @(negedge clk);
    end
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic drain_results();
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic run_phase(input cfg_t c, input int unsigned send_pct,
                           input int unsigned recv_pct);
    int unsigned      stop_at;
    int unsigned      pick;
    logic [ByteW-1:0] filler;
    write_config(c);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = bytes_sent + PhaseBudget;
    // Mostly well-formed packets with random content, the rest broken ones.
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 62)      send_packet(PktGood, 1'b0);
      else if (pick < 74) send_packet(PktBadSum, 1'b0);
      else if (pick < 85) send_packet(PktBadHeader, 1'b0);
      else if (pick < 93) send_packet(PktShortSync, 1'b0);
      else                send_packet(PktNoise, 1'b0);
    end
    // A full packet length of a word that matches no register walks the
    // parser back to hunting from any point before the next write.
    filler = 8'h00;
    while (filler == c.sync_value || filler == c.size_value ||
           filler == c.device_value || filler == c.message_value) filler++;
    repeat (PacketLength) send_byte(filler);
    rx_valid <= 1'b0;
    @(negedge clk);
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset settings.
    send_idle_pct = 29;
    recv_idle_pct = 59;
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(cur_cfg.sync_value);
    send_byte(cur_cfg.sync_value);
    send_byte(8'h00);
    // A fifth sync word lands on the size slot and must not restart the sync.
    repeat (SyncCount + 1) send_byte(cur_cfg.sync_value);
    send_packet(PktGood, 1'b1);
    send_packet(PktBadSum, 1'b0);
    send_packet(PktBadHeader, 1'b0);
    rx_valid <= 1'b0;
    @(negedge clk);
    drain_results();

    run_phase('{8'h00, 8'h00, 8'h00, 8'h00}, 29, 59);
    run_phase('{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 29, 59);
    run_phase('{ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                ByteW'($urandom_range(255)), ByteW'($urandom_range(255))}, 59, 29);
    run_phase('{8'h00, 8'hFF, 8'h00, 8'hFF}, 59, 29);
    run_phase('{ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                ByteW'($urandom_range(255)), ByteW'($urandom_range(255))}, 0, 0);
    run_phase('{SyncReset, SizeReset, DeviceReset, MessageReset}, 0, 0);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("timeout with %0d payload words still owed", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
rtl/ipd_pkg.sv
rtl/ipd_front.sv
rtl/ipd_fifo.sv
rtl/ipd_back.sv
rtl/imu_packet_deframer_top.sv
dv/imu_packet_deframer_checker.sv
dv/imu_packet_deframer_top_test.sv
